// File: hw/rtl/tmr0_pkg.sv
// ----------------------------------------------------------------------------
// tmr0_pkg
// Shared types and constants for the prescaled 8/16-bit timer core.
// ----------------------------------------------------------------------------
`default_nettype none

package tmr0_pkg;

  // request operation codes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_EXT   = 2'd3
  } op_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_ADDR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ADDR    = 2'd2;

  // address reset values
  localparam logic [15:0] RST_CONTROL_ADDR = 16'd4053;
  localparam logic [15:0] RST_LOW_ADDR     = 16'd4054;
  localparam logic [15:0] RST_HIGH_ADDR    = 16'd4055;

  // control byte bit positions
  localparam int CTL_BYPASS  = 3;
  localparam int CTL_FALLING = 4;
  localparam int CTL_EXT     = 5;
  localparam int CTL_NARROW  = 6;
  localparam int CTL_RUN     = 7;

  // one incoming request
  typedef struct packed {
    op_t         op;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;
    logic        clock_level;
  } item_t;

  // one result
  typedef struct packed {
    logic [7:0] read_data;
    logic       read_claimed;
    logic       write_claimed;
    logic       overflow;
  } result_t;

  // prescaler compare mask for divide by 2 << sel
  function automatic logic [7:0] prescale_mask(input logic [2:0] sel);
    logic [7:0] m;
    case (sel)
      3'd0:    m = 8'h01;
      3'd1:    m = 8'h03;
      3'd2:    m = 8'h07;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h1F;
      3'd5:    m = 8'h3F;
      3'd6:    m = 8'h7F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tmr0_if.sv
// ----------------------------------------------------------------------------
// tmr0 channel interfaces
// Valid/ready channels for timer requests and timer results.
// ----------------------------------------------------------------------------
`default_nettype none

// request channel
interface tmr0_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] bus_addr;
  logic [7:0]  write_data;
  logic        clock_level;

  modport source (output valid, op, bus_addr, write_data, clock_level, input ready);
  modport sink   (input valid, op, bus_addr, write_data, clock_level, output ready);
endinterface

// result channel
interface tmr0_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_claimed;
  logic       write_claimed;
  logic       overflow;

  modport source (output valid, read_data, read_claimed, write_claimed, overflow,
                  input ready);
  modport sink   (input valid, read_data, read_claimed, write_claimed, overflow,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/timer0_prescaled_8_16_bit_core.sv
// ----------------------------------------------------------------------------
// timer0_prescaled_8_16_bit_core
// 8/16-bit timer with prescaler and bus-mapped control and count registers.
//
//   channel   dir   handshake         payload
//   in_if     in    valid/ready       op, bus_addr, write_data, clock_level
//   out_if    out   valid/ready       read_data, read_claimed, write_claimed,
//                                     overflow
//   cfg_*     in    cfg_we only       cfg_index, cfg_data
//
// An accepted request sits in the input register; its decode and count update
// then land in the result register, where the result is presented as valid.
// One request per cycle is sustained while results are taken; the timer state
// updates as each request moves from the input to the result register.
// Reset is synchronous; all timer state and both stage valids clear.
// A stalled result holds the result register, the input register fills behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module timer0_prescaled_8_16_bit_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  tmr0_in_if.sink                                in_if,
  tmr0_out_if.source                             out_if,
  input  wire logic                              cfg_we,
  input  wire logic [tmr0_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tmr0_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tmr0_pkg::*;

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t exec_res;
  logic    s1_adv;

  // stage moves when the result slot is free or being taken
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_item_r <= '{op: op_t'(in_if.op), bus_addr: in_if.bus_addr,
                     write_data: in_if.write_data, clock_level: in_if.clock_level};
    end
  end

  // timer execution
  tmr0_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (s1_adv),
    .item      (s1_item_r),
    .result    (exec_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= exec_res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.read_data     = out_res_r.read_data;
  assign out_if.read_claimed  = out_res_r.read_claimed;
  assign out_if.write_claimed = out_res_r.write_claimed;
  assign out_if.overflow      = out_res_r.overflow;

  // a result flags at most one of read hit, write hit and wrap
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_res_r.read_claimed, out_res_r.write_claimed,
                              out_res_r.overflow}))
    else $error("result flags more than one kind");

  // unclaimed results carry zero read data
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.read_claimed) |-> (out_res_r.read_data == 8'h00))
    else $error("read data without a claimed read");

  // a held request in the input stage stays until it moves on
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input stage lost a held request");

endmodule

`default_nettype wire

// File: hw/rtl/tmr0_exec.sv
// ----------------------------------------------------------------------------
// tmr0_exec
// Timer state, bus register decode and count/prescaler update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module tmr0_exec (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [tmr0_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tmr0_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                fire,
  input  wire tmr0_pkg::item_t                     item,
  output tmr0_pkg::result_t                        result
);
  import tmr0_pkg::*;

  logic [15:0] ctl_addr_r, low_addr_r, high_addr_r;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  latch_r, latch_nxt;
  logic [7:0]  pcount_r, pcount_nxt;
  logic [2:0]  psel_r, psel_nxt;
  logic        pon_r, pon_nxt;
  logic        fes_r, fes_nxt;
  logic        ext_r, ext_nxt;
  logic        wide_r, wide_nxt;
  logic        run_r, run_nxt;

  logic        hit_low, hit_high, hit_ctl, do_adv;
  logic [7:0]  pcount_inc;
  logic [15:0] count_inc;
  logic [7:0]  ctl_byte;

  // address registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_addr_r  <= RST_CONTROL_ADDR;
      low_addr_r  <= RST_LOW_ADDR;
      high_addr_r <= RST_HIGH_ADDR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONTROL_ADDR: ctl_addr_r  <= cfg_data;
        CFG_LOW_ADDR:     low_addr_r  <= cfg_data;
        CFG_HIGH_ADDR:    high_addr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // address decode, low byte first, then high latch, then control
  assign hit_low  = (item.bus_addr == low_addr_r);
  assign hit_high = (item.bus_addr == high_addr_r) && wide_r;
  assign hit_ctl  = (item.bus_addr == ctl_addr_r);

  assign ctl_byte = {run_r, ~wide_r, ext_r, fes_r, ~pon_r, psel_r};

  // count step source
  assign do_adv = ((item.op == OP_TICK) && !ext_r) ||
                  ((item.op == OP_EXT) && ext_r && (item.clock_level != fes_r));
  assign pcount_inc = pcount_r + 8'd1;
  assign count_inc  = wide_r ? (count_r + 16'd1) : {8'h00, count_r[7:0] + 8'd1};

  // next state and result
  always_comb begin
    count_nxt  = count_r;
    latch_nxt  = latch_r;
    pcount_nxt = pcount_r;
    psel_nxt   = psel_r;
    pon_nxt    = pon_r;
    fes_nxt    = fes_r;
    ext_nxt    = ext_r;
    wide_nxt   = wide_r;
    run_nxt    = run_r;
    result     = '0;
    case (item.op)
      OP_READ: begin
        if (hit_low) begin
          latch_nxt           = count_r[15:8];
          result.read_data    = count_r[7:0];
          result.read_claimed = 1'b1;
        end else if (hit_high) begin
          result.read_data    = latch_r;
          result.read_claimed = 1'b1;
        end else if (hit_ctl) begin
          result.read_data    = ctl_byte;
          result.read_claimed = 1'b1;
        end
      end
      OP_WRITE: begin
        if (hit_low) begin
          pcount_nxt           = 8'h00;
          count_nxt            = {wide_r ? latch_r : count_r[15:8], item.write_data};
          result.write_claimed = 1'b1;
        end else if (hit_high) begin
          latch_nxt            = item.write_data;
          result.write_claimed = 1'b1;
        end else if (hit_ctl) begin
          psel_nxt             = item.write_data[2:0];
          pon_nxt              = !item.write_data[CTL_BYPASS];
          fes_nxt              = item.write_data[CTL_FALLING];
          ext_nxt              = item.write_data[CTL_EXT];
          wide_nxt             = !item.write_data[CTL_NARROW];
          run_nxt              = item.write_data[CTL_RUN];
          result.write_claimed = 1'b1;
        end
      end
      default: begin
        if (do_adv) begin
          pcount_nxt = pcount_inc;
          if (run_r && (!pon_r || ((pcount_inc & prescale_mask(psel_r)) == 8'h00))) begin
            count_nxt       = count_inc;
            result.overflow = (count_inc == 16'h0000);
          end
        end
      end
    endcase
  end

  // timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      latch_r  <= '0;
      pcount_r <= '0;
      psel_r   <= '0;
      pon_r    <= 1'b0;
      fes_r    <= 1'b0;
      ext_r    <= 1'b0;
      wide_r   <= 1'b0;
      run_r    <= 1'b0;
    end else if (fire) begin
      count_r  <= count_nxt;
      latch_r  <= latch_nxt;
      pcount_r <= pcount_nxt;
      psel_r   <= psel_nxt;
      pon_r    <= pon_nxt;
      fes_r    <= fes_nxt;
      ext_r    <= ext_nxt;
      wide_r   <= wide_nxt;
      run_r    <= run_nxt;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the prescaled 8/16-bit timer core. A directed table
// covers reset values, unmapped addresses, 8- and 16-bit wrap and the external
// edge gating. A long random run follows over several address maps, shared
// addresses among them, and idle and stall patterns. Results are checked against
// hand-typed values in typed rows, else against a built-in timer predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmr0_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_PHASES   = 8;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tmr0_in_if  in_ch ();
  tmr0_out_if out_ch ();

  timer0_prescaled_8_16_bit_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // directed stimulus row, with an optional hand-typed result
  typedef struct {
    item_t   req;
    bit      typed;
    result_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  // predictor state: address map and timer registers
  logic [15:0] m_ctl_addr, m_low_addr, m_high_addr;
  logic [15:0] m_count;
  logic [7:0]  m_high_latch;
  logic [7:0]  m_prescale_cnt;
  logic [2:0]  m_prescale_sel;
  logic        m_prescale_on, m_falling, m_external, m_wide, m_run;

  result_t pending_res[$];
  int      mismatches;
  int      quiet_cycles;
  int      idle_pct;
  int      stall_pct;
  bit      typed_valid;
  result_t typed_res;

  // one tick through the prescaler, returns the wrap flag
  function automatic logic count_step();
    logic [8:0] div_mask;
    m_prescale_cnt = m_prescale_cnt + 8'd1;
    if (!m_run) return 1'b0;
    div_mask = (9'd2 << m_prescale_sel) - 9'd1;
    if (m_prescale_on && ((m_prescale_cnt & div_mask[7:0]) != 8'd0)) return 1'b0;
    m_count = m_count + 16'd1;
    if (!m_wide) m_count[15:8] = 8'd0;
    return m_count == 16'd0;
  endfunction

  // expected result of one request, updating the predicted timer state
  function automatic result_t timer_predict(input item_t req);
    result_t r;
    r = '0;
    case (req.op)
      OP_READ: begin
        if (req.bus_addr == m_low_addr) begin
          m_high_latch   = m_count[15:8];
          r.read_data    = m_count[7:0];
          r.read_claimed = 1'b1;
        end else if (req.bus_addr == m_high_addr && m_wide) begin
          r.read_data    = m_high_latch;
          r.read_claimed = 1'b1;
        end else if (req.bus_addr == m_ctl_addr) begin
          r.read_data[2:0]         = m_prescale_sel;
          r.read_data[CTL_BYPASS]  = !m_prescale_on;
          r.read_data[CTL_FALLING] = m_falling;
          r.read_data[CTL_EXT]     = m_external;
          r.read_data[CTL_NARROW]  = !m_wide;
          r.read_data[CTL_RUN]     = m_run;
          r.read_claimed           = 1'b1;
        end
      end
      OP_WRITE: begin
        if (req.bus_addr == m_low_addr) begin
          m_prescale_cnt = 8'd0;
          m_count[7:0]   = req.write_data;
          if (m_wide) m_count[15:8] = m_high_latch;
          r.write_claimed = 1'b1;
        end else if (req.bus_addr == m_high_addr && m_wide) begin
          m_high_latch    = req.write_data;
          r.write_claimed = 1'b1;
        end else if (req.bus_addr == m_ctl_addr) begin
          m_prescale_sel  = req.write_data[2:0];
          m_prescale_on   = !req.write_data[CTL_BYPASS];
          m_falling       = req.write_data[CTL_FALLING];
          m_external      = req.write_data[CTL_EXT];
          m_wide          = !req.write_data[CTL_NARROW];
          m_run           = req.write_data[CTL_RUN];
          r.write_claimed = 1'b1;
        end
      end
      OP_TICK: begin
        if (!m_external) r.overflow = count_step();
      end
      default: begin
        // any level other than the idle level of the selected edge counts
        if (m_external && (req.clock_level != m_falling)) r.overflow = count_step();
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t %s: expected data=%02h rc=%0b wc=%0b ovf=%0b, got data=%02h rc=%0b wc=%0b ovf=%0b",
               $realtime, what, want.read_data, want.read_claimed, want.write_claimed,
               want.overflow, got.read_data, got.read_claimed, got.write_claimed, got.overflow);
  endtask

  // prediction on accepted requests, checking on accepted results
  always @(posedge clk) begin
    item_t   req;
    result_t got;
    result_t want;
    if (!rst_n) begin
      m_ctl_addr     = RST_CONTROL_ADDR;
      m_low_addr     = RST_LOW_ADDR;
      m_high_addr    = RST_HIGH_ADDR;
      m_count        = '0;
      m_high_latch   = '0;
      m_prescale_cnt = '0;
      m_prescale_sel = '0;
      m_prescale_on  = 1'b0;
      m_falling      = 1'b0;
      m_external     = 1'b0;
      m_wide         = 1'b0;
      m_run          = 1'b0;
      pending_res.delete();
      quiet_cycles   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CONTROL_ADDR: m_ctl_addr  = cfg_data;
          CFG_LOW_ADDR:     m_low_addr  = cfg_data;
          CFG_HIGH_ADDR:    m_high_addr = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        req.op          = op_t'(in_ch.op);
        req.bus_addr    = in_ch.bus_addr;
        req.write_data  = in_ch.write_data;
        req.clock_level = in_ch.clock_level;
        want = timer_predict(req);
        pending_res.push_back(typed_valid ? typed_res : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.read_data     = out_ch.read_data;
        got.read_claimed  = out_ch.read_claimed;
        got.write_claimed = out_ch.write_claimed;
        got.overflow      = out_ch.overflow;
        if (pending_res.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_res.pop_front();
          if (got !== want) report_mismatch("result mismatch", want, got);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result-side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic add_row(input op_t op, input logic [15:0] addr, input logic [7:0] data,
                         input logic lvl, input bit typed, input logic [7:0] rd,
                         input logic rc, input logic wc, input logic ov);
    dir_row_t row;
    row.req.op          = op;
    row.req.bus_addr    = addr;
    row.req.write_data  = data;
    row.req.clock_level = lvl;
    row.typed           = typed;
    row.res.read_data     = rd;
    row.res.read_claimed  = rc;
    row.res.write_claimed = wc;
    row.res.overflow      = ov;
    dir_rows.push_back(row);
  endtask

  // present one request, entered and left at a falling edge
  task automatic send_req(input item_t req, input bit typed, input result_t res);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= req.op;
    in_ch.bus_addr    <= req.bus_addr;
    in_ch.write_data  <= req.write_data;
    in_ch.clock_level <= req.clock_level;
    typed_valid = typed;
    typed_res   = res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and let every outstanding result drain
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  // bytes near the wrap point show up half of the time
  function automatic logic [7:0] near_wrap_byte();
    if ($urandom_range(1)) return 8'hF8 | 8'($urandom_range(7));
    return 8'($urandom);
  endfunction

  // random request, mostly well-formed accesses and ticks on the current map
  function automatic item_t random_req();
    item_t req;
    int    pick;
    pick            = $urandom_range(99);
    req.bus_addr    = 16'($urandom);
    req.write_data  = 8'($urandom);
    req.clock_level = 1'($urandom);
    if (pick < 8) begin
      req.op = OP_WRITE;
      req.bus_addr = m_ctl_addr;
      if ($urandom_range(3) != 0) req.write_data[CTL_RUN] = 1'b1;
      if ($urandom_range(1)) req.write_data[CTL_BYPASS] = 1'b1;
    end else if (pick < 14) begin
      req.op = OP_WRITE;
      req.bus_addr = m_low_addr;
      req.write_data = near_wrap_byte();
    end else if (pick < 18) begin
      req.op = OP_WRITE;
      req.bus_addr = m_high_addr;
      req.write_data = near_wrap_byte();
    end else if (pick < 26) begin
      req.op = OP_READ;
      case ($urandom_range(2))
        0:       req.bus_addr = m_low_addr;
        1:       req.bus_addr = m_high_addr;
        default: req.bus_addr = m_ctl_addr;
      endcase
    end else if (pick < 30) begin
      // stray access at a random address
      req.op = $urandom_range(1) ? OP_WRITE : OP_READ;
    end else if (pick < 65) begin
      req.op = OP_TICK;
    end else begin
      req.op = OP_EXT;
    end
    return req;
  endfunction

  // stimulus
  initial begin
    logic [15:0] addr_map[NUM_PHASES][3];
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_READ;
    in_ch.bus_addr    = '0;
    in_ch.write_data  = '0;
    in_ch.clock_level = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_CONTROL_ADDR;
    cfg_data          = '0;
    rst_n             = 1'b0;
    idle_pct          = 0;
    stall_pct         = 0;
    typed_valid       = 1'b0;
    typed_res         = '0;
    mismatches        = 0;

    // address maps per phase: reset map, extremes, shared addresses and a random map
    addr_map[0] = '{RST_CONTROL_ADDR, RST_LOW_ADDR, RST_HIGH_ADDR};
    addr_map[1] = '{16'd0, 16'd1, 16'hFFFF};
    addr_map[2] = '{16'hFFFF, 16'd0, 16'd1};
    addr_map[3] = '{16'd7, 16'd7, 16'd7};
    addr_map[4] = '{16'd40, 16'd41, 16'd40};
    addr_map[5] = '{16'd50, 16'd51, 16'd51};
    addr_map[6] = '{16'd60, 16'd60, 16'd61};
    addr_map[7] = '{16'($urandom), 16'($urandom), 16'($urandom)};

    // directed table on the reset address map
    add_row(OP_READ,  RST_CONTROL_ADDR, 8'h00, 1'b0, 1, 8'h48, 1, 0, 0);
    add_row(OP_READ,  RST_LOW_ADDR,     8'h00, 1'b0, 1, 8'h00, 1, 0, 0);
    add_row(OP_READ,  RST_HIGH_ADDR,    8'h00, 1'b0, 1, 8'h00, 0, 0, 0);
    add_row(OP_WRITE, RST_HIGH_ADDR,    8'hFF, 1'b1, 1, 8'h00, 0, 0, 0);
    add_row(OP_TICK,  16'd0,            8'h00, 1'b0, 1, 8'h00, 0, 0, 0);
    add_row(OP_EXT,   16'd0,            8'h00, 1'b1, 1, 8'h00, 0, 0, 0);
    add_row(OP_READ,  16'd0,            8'h00, 1'b0, 1, 8'h00, 0, 0, 0);
    add_row(OP_READ,  16'hFFFF,         8'hFF, 1'b1, 1, 8'h00, 0, 0, 0);
    add_row(OP_WRITE, 16'hFFFF,         8'hAA, 1'b0, 1, 8'h00, 0, 0, 0);
    // 8-bit mode, running, prescaler bypassed: wrap after two ticks
    add_row(OP_WRITE, RST_CONTROL_ADDR, 8'hC8, 1'b0, 1, 8'h00, 0, 1, 0);
    add_row(OP_WRITE, RST_LOW_ADDR,     8'hFE, 1'b0, 1, 8'h00, 0, 1, 0);
    add_row(OP_TICK,  16'd0,            8'h00, 1'b0, 1, 8'h00, 0, 0, 0);
    add_row(OP_TICK,  16'd0,            8'h00, 1'b0, 1, 8'h00, 0, 0, 1);
    add_row(OP_READ,  RST_LOW_ADDR,     8'h00, 1'b0, 1, 8'h00, 1, 0, 0);
    // 16-bit mode: high byte loads through the latch on the low write
    add_row(OP_WRITE, RST_CONTROL_ADDR, 8'h88, 1'b0, 1, 8'h00, 0, 1, 0);
    add_row(OP_WRITE, RST_HIGH_ADDR,    8'hFF, 1'b0, 1, 8'h00, 0, 1, 0);
    add_row(OP_WRITE, RST_LOW_ADDR,     8'hFF, 1'b0, 1, 8'h00, 0, 1, 0);
    add_row(OP_TICK,  16'd0,            8'h00, 1'b0, 1, 8'h00, 0, 0, 1);
    // external falling edges with divide by 256; internal ticks ignored
    add_row(OP_WRITE, RST_CONTROL_ADDR, 8'hB7, 1'b0, 1, 8'h00, 0, 1, 0);
    add_row(OP_TICK,  16'd0,            8'h00, 1'b0, 0, 8'h00, 0, 0, 0);
    add_row(OP_EXT,   16'd0,            8'h00, 1'b0, 0, 8'h00, 0, 0, 0);
    add_row(OP_EXT,   16'd0,            8'h00, 1'b1, 0, 8'h00, 0, 0, 0);
    add_row(OP_READ,  RST_CONTROL_ADDR, 8'h00, 1'b0, 1, 8'hB7, 1, 0, 0);
    add_row(OP_READ,  RST_HIGH_ADDR,    8'h00, 1'b0, 0, 8'h00, 0, 0, 0);
    add_row(OP_WRITE, RST_CONTROL_ADDR, 8'h7F, 1'b0, 1, 8'h00, 0, 1, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    // random phases over address maps, idle and stall patterns
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      cfg_write(CFG_CONTROL_ADDR, addr_map[ph][0]);
      cfg_write(CFG_LOW_ADDR,     addr_map[ph][1]);
      cfg_write(CFG_HIGH_ADDR,    addr_map[ph][2]);
      cfg_we <= 1'b0;
      @(negedge clk);
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 61; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_req(random_req(), 1'b0, '0);
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
